@@ sv/lat_pkg.sv @@
package lat_pkg;

	localparam int WordBits = 32;
	localparam int FracBits = 16;
	localparam int CoefBits = 16;
	localparam int IdxBits  = 3;
	localparam int DivSteps = 32;

	localparam logic [WordBits-1:0] MinInit  = '1;
	localparam logic [WordBits-1:0] AccPosMax = {1'b0, {(WordBits-1){1'b1}}};
	localparam logic [WordBits-1:0] AccNegMag = {1'b1, {(WordBits-1){1'b0}}};
	localparam logic [CoefBits-1:0] CoefInit = {1'b1, {(CoefBits-1){1'b0}}};

	typedef enum logic [IdxBits-1:0] {
		REG_FIELD_X   = 3'd0,
		REG_FIELD_Y   = 3'd1,
		REG_FIELD_Z   = 3'd2,
		REG_FLOOR_SQ  = 3'd3,
		REG_STEP_COEF = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] charge;
		logic [30:0]        mass;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic               last;
	} particle_t;

	typedef struct packed {
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic [31:0]        floor_sq;
		logic [15:0]        coef;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [63:0] rem0;
		logic [63:0] den;
		logic [31:0] low;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P1,
		ST_P2,
		ST_QLO,
		ST_QHI,
		ST_SUM,
		ST_ADIV,
		ST_AWAIT,
		ST_SQ,
		ST_CMP,
		ST_RWAIT,
		ST_EST,
		ST_OUT
	} bk_state_t;

	function automatic logic [32:0] clamp_comp(input logic ovf, input logic [31:0] q,
		input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (ovf || q > AccNegMag) r = {1'b1, AccNegMag};
			else r = {1'b0, 32'd0 - q};
		end else begin
			if (ovf || q[31]) r = {1'b1, AccPosMax};
			else r = {1'b0, q};
		end
		return r;
	endfunction

	function automatic logic signed [32:0] mag33(input logic signed [31:0] x);
		logic signed [32:0] s;
		s = {x[31], x};
		return x[31] ? -s : s;
	endfunction

endpackage

@@ sv/lat_if.sv @@
interface lat_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] charge_in;
	logic [30:0]        mass_in;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic               last_particle;

	modport source(output valid, charge_in, mass_in, vel_x, vel_y, vel_z, last_particle,
		input ready);
	modport sink(input valid, charge_in, mass_in, vel_x, vel_y, vel_z, last_particle,
		output ready);
endinterface

interface lat_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] acc_x;
	logic signed [31:0] acc_y;
	logic signed [31:0] acc_z;
	logic               out_of_range;
	logic [31:0]        step_estimate;
	logic               last_out;

	modport source(output valid, acc_x, acc_y, acc_z, out_of_range, step_estimate, last_out,
		input ready);
	modport sink(input valid, acc_x, acc_y, acc_z, out_of_range, step_estimate, last_out,
		output ready);
endinterface

@@ sv/lat_front.sv @@
module lat_front (
	input  logic              clk,
	input  logic              arst_n,
	lat_in_if.sink            item,
	output logic              pvalid,
	output lat_pkg::particle_t pdata,
	input  logic              pop
);
	import lat_pkg::*;

	particle_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign item.ready = (count_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign pvalid     = (count_q != 2'd0);
	assign pdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{charge: item.charge_in, mass: item.mass_in, vx: item.vel_x,
				vy: item.vel_y, vz: item.vel_z, last: item.last_particle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule

@@ sv/lat_div.sv @@
module lat_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lat_pkg::div_req_t req,
	output lat_pkg::div_rsp_t rsp
);
	import lat_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [31:0] low_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] sh;
	logic [64:0] diff;
	logic        ge;

	assign sh   = {rem_q, low_q[31]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});
	assign rsp  = '{done: done_q, quo: quo_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			den_q <= req.den;
			low_q <= req.low;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : sh[63:0];
			low_q <= {low_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ sv/lat_back.sv @@
module lat_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lat_pkg::cfg_t      cfg,
	input  logic               pvalid,
	input  lat_pkg::particle_t pdata,
	output logic               pop,
	output lat_pkg::div_req_t  dreq,
	input  lat_pkg::div_rsp_t  drsp,
	lat_out_if.source          result
);
	import lat_pkg::*;

	bk_state_t          state_q, state_nx;
	particle_t          item_q;
	logic [1:0]         comp_q;
	logic [2:0]         sq_cnt_q;
	logic signed [63:0] p1_q;
	logic [63:0]        cmag_q;
	logic               neg_q;
	logic [63:0]        lo_q;
	logic [63:0]        hi_q;
	logic [95:0]        num_q;
	logic signed [31:0] acc_q [3];
	logic               flag_q;
	logic [63:0]        prod_q;
	logic [63:0]        vmag_q;
	logic [63:0]        amag_q;
	logic [31:0]        min_q;
	logic [31:0]        est_q;
	logic               out_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [31:0] u1, b2, u2, b1;
	logic signed [32:0] qmag;
	logic signed [64:0] diff;
	logic [63:0]        cmag;
	logic               aovf;
	logic               counts;
	logic               rsat;
	logic [32:0]        cres;
	logic               cres_ovf;
	logic [31:0]        cres_q;
	logic               out_load;
	logic [47:0]        est_p;
	logic signed [31:0] sq_src;

	always_comb begin
		case (comp_q)
			2'd0: begin u1 = item_q.vy; b2 = cfg.bz; u2 = item_q.vz; b1 = cfg.by; end
			2'd1: begin u1 = item_q.vz; b2 = cfg.bx; u2 = item_q.vx; b1 = cfg.bz; end
			default: begin u1 = item_q.vx; b2 = cfg.by; u2 = item_q.vy; b1 = cfg.bx; end
		endcase
	end

	always_comb begin
		case (sq_cnt_q)
			3'd0: sq_src = item_q.vx;
			3'd1: sq_src = item_q.vy;
			3'd2: sq_src = item_q.vz;
			3'd3: sq_src = acc_q[0];
			3'd4: sq_src = acc_q[1];
			default: sq_src = acc_q[2];
		endcase
	end

	assign qmag   = mag33(item_q.charge);
	assign mul_p  = mul_a * mul_b;
	assign diff   = $signed({p1_q[63], p1_q}) - $signed(mul_p[64:0]);
	assign cmag   = diff[64] ? 64'(-diff) : diff[63:0];
	assign aovf   = (num_q[95:48] >= {17'd0, item_q.mass});
	assign counts = (amag_q > {16'd0, cfg.floor_sq, 16'd0});
	assign rsat   = ({16'd0, vmag_q[63:16]} >= amag_q);
	assign cres_ovf = (state_q == ST_ADIV);
	assign cres_q   = drsp.quo;
	assign cres     = clamp_comp(cres_ovf, cres_q, neg_q);
	assign est_p    = cfg.coef * min_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_P1: begin mul_a = {u1[31], u1}; mul_b = {b2[31], b2}; end
			ST_P2: begin mul_a = {u2[31], u2}; mul_b = {b1[31], b1}; end
			ST_QLO: begin mul_a = qmag; mul_b = {1'b0, cmag_q[31:0]}; end
			ST_QHI: begin mul_a = qmag; mul_b = {1'b0, cmag_q[63:32]}; end
			ST_SQ: begin mul_a = mag33(sq_src); mul_b = mag33(sq_src); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pvalid) state_nx = (pdata.mass == '0) ? ST_SQ : ST_P1;
			end
			ST_P1: state_nx = ST_P2;
			ST_P2: state_nx = ST_QLO;
			ST_QLO: state_nx = ST_QHI;
			ST_QHI: state_nx = ST_SUM;
			ST_SUM: state_nx = ST_ADIV;
			ST_ADIV: begin
				if (aovf) state_nx = (comp_q == 2'd2) ? ST_SQ : ST_P1;
				else state_nx = ST_AWAIT;
			end
			ST_AWAIT: begin
				if (drsp.done) state_nx = (comp_q == 2'd2) ? ST_SQ : ST_P1;
			end
			ST_SQ: begin
				if (sq_cnt_q == 3'd6) state_nx = ST_CMP;
			end
			ST_CMP: state_nx = (counts && !rsat) ? ST_RWAIT : ST_EST;
			ST_RWAIT: begin
				if (drsp.done) state_nx = ST_EST;
			end
			ST_EST: state_nx = ST_OUT;
			ST_OUT: begin
				if (out_load) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		dreq = '{start: 1'b0, rem0: {16'd0, vmag_q[63:16]}, den: amag_q,
			low: {vmag_q[15:0], 16'd0}};
		case (state_q)
			ST_IDLE: pop = pvalid;
			ST_ADIV: begin
				dreq = '{start: !aovf, rem0: {16'd0, num_q[95:48]}, den: {33'd0, item_q.mass},
					low: num_q[47:16]};
			end
			ST_CMP: dreq.start = counts && !rsat;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= pdata;
				comp_q <= 2'd0;
				flag_q <= (pdata.mass == '0);
				vmag_q <= '0;
				amag_q <= '0;
				sq_cnt_q <= '0;
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			end
			ST_P1: p1_q <= mul_p[63:0];
			ST_P2: begin
				cmag_q <= cmag;
				neg_q  <= diff[64] ^ item_q.charge[31];
			end
			ST_QLO: lo_q <= mul_p[63:0];
			ST_QHI: hi_q <= mul_p[63:0];
			ST_SUM: num_q <= {32'd0, lo_q} + {hi_q, 32'd0};
			ST_ADIV: begin
				if (aovf) begin
					acc_q[comp_q] <= cres[31:0];
					flag_q <= 1'b1;
					comp_q <= comp_q + 2'd1;
				end
			end
			ST_AWAIT: begin
				if (drsp.done) begin
					acc_q[comp_q] <= cres[31:0];
					if (cres[32]) flag_q <= 1'b1;
					comp_q <= comp_q + 2'd1;
				end
			end
			ST_SQ: begin
				prod_q   <= mul_p[63:0];
				sq_cnt_q <= sq_cnt_q + 3'd1;
				if (sq_cnt_q != 3'd0) begin
					if (sq_cnt_q <= 3'd3) vmag_q <= vmag_q + prod_q;
					else amag_q <= amag_q + prod_q;
				end
			end
			ST_EST: est_q <= item_q.last ? est_p[47:16] : '0;
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= MinInit;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_RWAIT && drsp.done && drsp.quo < min_q) min_q <= drsp.quo;
			if (state_q == ST_EST && item_q.last) min_q <= MinInit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.acc_x         <= acc_q[0];
			result.acc_y         <= acc_q[1];
			result.acc_z         <= acc_q[2];
			result.out_of_range  <= flag_q;
			result.step_estimate <= est_q;
			result.last_out      <= item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	assign result.valid = out_valid_q;
endmodule

@@ sv/lorentz_accel_timestep.sv @@
// Each particle of nonzero mass has its three components divided and, unless skipped, its
// ratio; a component whose quotient would overflow skips its division, and a particle of
// zero mass divides nothing. The back end works on one particle at a time and shares one
// radix-2 divider that runs 32 steps for each of three components and the ratio.
// A two-word queue takes particles while the back end works; results sit in one register.
// Reset: field and floor registers clear, coefficient goes to one half, minimum to all ones.
module lorentz_accel_timestep (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	lat_in_if.sink      item,
	lat_out_if.source   result
);
	import lat_pkg::*;

	cfg_t      cfg_q;
	logic      pvalid;
	particle_t pdata;
	logic      pop;
	div_req_t  dreq;
	div_rsp_t  drsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bx       <= '0;
			cfg_q.by       <= '0;
			cfg_q.bz       <= '0;
			cfg_q.floor_sq <= '0;
			cfg_q.coef     <= CoefInit;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FIELD_X: cfg_q.bx <= cfg_data;
				REG_FIELD_Y: cfg_q.by <= cfg_data;
				REG_FIELD_Z: cfg_q.bz <= cfg_data;
				REG_FLOOR_SQ: cfg_q.floor_sq <= cfg_data;
				REG_STEP_COEF: cfg_q.coef <= cfg_data[15:0];
				default: begin end
			endcase
		end
	end

	lat_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.pvalid (pvalid),
		.pdata  (pdata),
		.pop    (pop)
	);

	lat_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	lat_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pvalid (pvalid),
		.pdata  (pdata),
		.pop    (pop),
		.dreq   (dreq),
		.drsp   (drsp),
		.result (result)
	);
endmodule

@@ test/tb_lorentz_accel_timestep.sv @@
`timescale 1ns / 1ps

module tb_lorentz_accel_timestep;
	import lat_pkg::*;

	localparam int CycleLimit = 1500000;

	typedef struct {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic               oor;
		logic [31:0]        est;
		logic               last;
	} accel_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lat_in_if  item_bus();
	lat_out_if result_bus();

	lorentz_accel_timestep DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(item_bus), .result(result_bus)
	);

	cfg_t        field_cfg;
	logic [31:0] ratio_min;
	accel_word_t accel_queue[$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          hold_cycles = 0;
	bit          steady = 1'b0;

	always #5 clk = ~clk;

	initial begin
		item_bus.valid = 1'b0;
		item_bus.charge_in = '0;
		item_bus.mass_in = '0;
		item_bus.vel_x = '0;
		item_bus.vel_y = '0;
		item_bus.vel_z = '0;
		item_bus.last_particle = 1'b0;
		result_bus.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		return x[31] ? 32'd0 - x : x;
	endfunction

	// returns {saturated, component}
	function automatic logic [32:0] lorentz_part(input logic signed [31:0] u1,
		input logic signed [31:0] b2, input logic signed [31:0] u2,
		input logic signed [31:0] b1, input logic [31:0] qmag, input logic qneg,
		input logic [30:0] m);
		logic signed [63:0] p1, p2;
		logic [63:0]  cmag, mag;
		logic [127:0] prod, quo;
		logic         neg;
		p1 = 64'(u1) * 64'(b2);
		p2 = 64'(u2) * 64'(b1);
		if (p1 >= p2) begin
			cmag = p1 - p2;
			neg = 1'b0;
		end else begin
			cmag = p2 - p1;
			neg = 1'b1;
		end
		neg = neg ^ qneg;
		prod = 128'(qmag) * 128'(cmag);
		quo = prod / 128'(m);
		if ((quo >> 80) != 0) mag = '1;
		else mag = quo[79:16];
		if (neg) begin
			if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
			return {1'b0, 32'd0 - mag[31:0]};
		end
		if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
		return {1'b0, mag[31:0]};
	endfunction

	function automatic accel_word_t predict_accel(input particle_t p);
		accel_word_t w;
		logic [32:0]  cx, cy, cz;
		logic [31:0]  qmag;
		logic [63:0]  v2, a2, t;
		logic [127:0] rq;
		logic [31:0]  ratio;
		w.ax = 0;
		w.ay = 0;
		w.az = 0;
		w.oor = 1'b0;
		w.est = 0;
		w.last = p.last;
		if (p.mass == 0) begin
			w.oor = 1'b1;
		end else begin
			qmag = abs32(p.charge);
			cx = lorentz_part(p.vy, field_cfg.bz, p.vz, field_cfg.by, qmag, p.charge[31],
				p.mass);
			cy = lorentz_part(p.vz, field_cfg.bx, p.vx, field_cfg.bz, qmag, p.charge[31],
				p.mass);
			cz = lorentz_part(p.vx, field_cfg.by, p.vy, field_cfg.bx, qmag, p.charge[31],
				p.mass);
			w.ax = cx[31:0];
			w.ay = cy[31:0];
			w.az = cz[31:0];
			w.oor = cx[32] | cy[32] | cz[32];
		end
		t = abs32(p.vx); v2 = t * t;
		t = abs32(p.vy); v2 += t * t;
		t = abs32(p.vz); v2 += t * t;
		t = abs32(w.ax); a2 = t * t;
		t = abs32(w.ay); a2 += t * t;
		t = abs32(w.az); a2 += t * t;
		if (a2 > (64'(field_cfg.floor_sq) << FracBits)) begin
			rq = (128'(v2) << FracBits) / 128'(a2);
			ratio = ((rq >> 32) != 0) ? 32'hFFFF_FFFF : rq[31:0];
			if (ratio < ratio_min) ratio_min = ratio;
		end
		if (p.last) begin
			t = 64'(field_cfg.coef) * 64'(ratio_min);
			w.est = t[47:16];
			ratio_min = MinInit;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_bus.ready = 1'b0;
			hold_cycles--;
		end else if (steady) begin
			result_bus.ready = 1'b1;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:69]:  result_bus.ready = 1'b1;
				[70:96]: result_bus.ready = 1'b0;
				default: begin
					result_bus.ready = 1'b0;
					hold_cycles = $urandom_range(10, 40);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		accel_word_t w;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (accel_queue.size() == 0) begin
				report_mismatch("unexpected word", result_bus.acc_x, 0);
			end else begin
				w = accel_queue.pop_front();
				if (result_bus.acc_x !== w.ax) report_mismatch("acc_x", result_bus.acc_x, w.ax);
				if (result_bus.acc_y !== w.ay) report_mismatch("acc_y", result_bus.acc_y, w.ay);
				if (result_bus.acc_z !== w.az) report_mismatch("acc_z", result_bus.acc_z, w.az);
				if (result_bus.out_of_range !== w.oor)
					report_mismatch("out_of_range", 32'(result_bus.out_of_range), 32'(w.oor));
				if (result_bus.step_estimate !== w.est)
					report_mismatch("step_estimate", result_bus.step_estimate, w.est);
				if (result_bus.last_out !== w.last)
					report_mismatch("last_out", 32'(result_bus.last_out), 32'(w.last));
			end
		end
	end

	task automatic send_particle(input particle_t p);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.charge_in = p.charge;
		item_bus.mass_in = p.mass;
		item_bus.vel_x = p.vx;
		item_bus.vel_y = p.vy;
		item_bus.vel_z = p.vz;
		item_bus.last_particle = p.last;
		item_bus.valid = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		accel_queue.push_back(predict_accel(p));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (accel_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_FIELD_X:   field_cfg.bx = data;
			REG_FIELD_Y:   field_cfg.by = data;
			REG_FIELD_Z:   field_cfg.bz = data;
			REG_FLOOR_SQ:  field_cfg.floor_sq = data;
			REG_STEP_COEF: field_cfg.coef = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_field(input logic [31:0] bx, input logic [31:0] by,
		input logic [31:0] bz, input logic [31:0] fl, input logic [15:0] coef);
		write_reg(REG_FIELD_X, bx);
		write_reg(REG_FIELD_Y, by);
		write_reg(REG_FIELD_Z, bz);
		write_reg(REG_FLOOR_SQ, fl);
		write_reg(REG_STEP_COEF, {16'd0, coef});
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0020_0000))) - 32'h0010_0000;
		endcase
	endfunction

	function automatic particle_t rand_particle(input int last_pct);
		particle_t p;
		p.charge = rand_word();
		case ($urandom_range(0, 19))
			0: p.mass = '0;
			1: p.mass = 31'h7FFF_FFFF;
			2, 3, 4: p.mass = 31'($urandom);
			default: p.mass = 31'($urandom_range(1, 32'h0004_0000));
		endcase
		p.vx = rand_word();
		p.vy = rand_word();
		p.vz = rand_word();
		p.last = ($urandom_range(0, 99) < last_pct);
		return p;
	endfunction

	function automatic particle_t mk(input logic [31:0] q, input logic [30:0] m,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] z, input logic l);
		particle_t p;
		p.charge = q; p.mass = m; p.vx = x; p.vy = y; p.vz = z; p.last = l;
		return p;
	endfunction

	task automatic test_reset_state();
		send_particle(mk(32'h0001_0000, 31'h0001_0000, 32'h0001_0000, 0, 0, 1'b1));
		send_particle(mk(0, 0, 0, 0, 0, 1'b1));
		wait_drained();
	endtask

	task automatic test_directed();
		write_field(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 0, 16'hFFFF);
		send_particle(mk(32'h0001_0000, 31'h0001_0000, 32'h0001_0000, 32'h0003_0000,
			32'hFFFE_0000, 1'b0));
		send_particle(mk(32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			1'b0));
		send_particle(mk(32'h8000_0000, 31'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			1'b0));
		send_particle(mk(32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 1'b0));
		send_particle(mk(32'hFFFF_0000, 31'h7FFF_FFFF, 32'h0010_0000, 0, 32'h0000_0001,
			1'b1));
		send_particle(mk(32'h0000_0001, 31'h7FFF_FFFF, 32'h0000_0001, 0, 0, 1'b1));
		send_particle(mk(32'h8000_0000, 31'h0000_0001, 32'h0000_0100, 32'h0000_0200, 0,
			1'b1));
		wait_drained();
		write_field(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
		send_particle(mk(32'h0000_0100, 31'h0100_0000, 32'h0000_1000, 32'h0000_2000,
			32'h0000_3000, 1'b0));
		send_particle(mk(32'h7FFF_FFFF, 31'h0001_0000, 32'h0001_0000, 0, 0, 1'b1));
		wait_drained();
		write_field(32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 32'h0000_0001, 16'h0001);
		send_particle(mk(32'h0001_0000, 31'h0001_0000, 32'h0000_0010, 32'h0000_0020,
			32'h0000_0030, 1'b0));
		send_particle(mk(32'h0001_0000, 31'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
			32'hFFFF_0000, 1'b1));
		wait_drained();
		write_reg(reg_idx_t'(3'd6), 32'hDEAD_BEEF);
		write_reg(reg_idx_t'(3'd7), 32'h1234_5678);
		send_particle(mk(32'h0002_0000, 31'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0,
			1'b1));
		wait_drained();
	endtask

	task automatic test_random_sweep();
		for (int phase = 0; phase < 15; phase++) begin
			case (phase % 3)
				0: write_field(rand_word(), rand_word(), rand_word(),
					$urandom_range(0, 16), 16'($urandom));
				1: write_field($urandom, $urandom, $urandom, $urandom, 16'($urandom));
				default: write_field(rand_word(), rand_word(), rand_word(),
					(phase % 2) ? 32'hFFFF_FFFF : 32'd0, (phase % 2) ? 16'hFFFF : 16'd0);
			endcase
			steady = (phase % 4 == 3);
			for (int i = 0; i < 46; i++) send_particle(rand_particle(12));
			steady = 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_cycles = 600;
		for (int i = 0; i < 8; i++) send_particle(rand_particle(30));
		wait_drained();
	endtask

	initial begin
		field_cfg = '{bx: 0, by: 0, bz: 0, floor_sq: 0, coef: CoefInit};
		ratio_min = MinInit;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_directed();
		test_backpressure();
		test_random_sweep();
		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lat_pkg.sv
sv/lat_if.sv
sv/lat_front.sv
sv/lat_div.sv
sv/lat_back.sv
sv/lorentz_accel_timestep.sv
test/tb_lorentz_accel_timestep.sv
